>>> rtl/msnf_pkg.sv
// Shared types and constants of the monotonic stack neighbor finder.
package msnf_pkg;

  localparam int STACK_DEPTH_DEF   = 64;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic MODE_GREATER = 1'b0;
  localparam logic MODE_SMALLER = 1'b1;

  localparam int OP_BITS = 2;

  // Classified operation, as the stack engine carries it out.
  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_GREATER = 2'd0,
    OP_PUSH_SMALLER = 2'd1,
    OP_FLUSH_REPORT = 2'd2,
    OP_FLUSH_CLEAR  = 2'd3
  } op_t;

  localparam int FLAG_BITS = 3;

  typedef struct packed {
    logic found;
    logic status;
    logic last_of_run;
  } res_flags_t;

endpackage

>>> rtl/msnf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/msnf_fifo.sv
// Small register-based word queue.
module msnf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_wr;
  logic                do_rd;

  assign full    = (fill == CNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/msnf_front.sv
// Front end: accepts input words, classifies them by mode and queues them.
module msnf_front
  import msnf_pkg::*;
#(
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            mode,
  input  logic                            push,
  output logic                            full,
  input  logic                            command,
  input  logic signed [VALUE_BITS-1:0]    elem_value,
  input  logic        [POSITION_BITS-1:0] elem_position,
  output logic                            head_valid,
  output op_t                             head_op,
  output logic signed [VALUE_BITS-1:0]    head_value,
  output logic        [POSITION_BITS-1:0] head_position,
  input  logic                            head_pop
);

  localparam int ITEM_BITS = OP_BITS + VALUE_BITS + POSITION_BITS;

  op_t                  op;
  logic [ITEM_BITS-1:0] wr_item;
  logic [ITEM_BITS-1:0] rd_item;
  logic                 empty;

  always_comb begin
    unique case ({command, mode})
      {CMD_PUSH,  MODE_GREATER}: op = OP_PUSH_GREATER;
      {CMD_PUSH,  MODE_SMALLER}: op = OP_PUSH_SMALLER;
      {CMD_FLUSH, MODE_GREATER}: op = OP_FLUSH_REPORT;
      default:                   op = OP_FLUSH_CLEAR;
    endcase
  end

  assign wr_item = {op, elem_value, elem_position};

  msnf_fifo #(
    .WIDTH (ITEM_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (wr_item),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (rd_item),
    .empty   (empty)
  );

  assign head_valid    = !empty;
  assign head_op       = op_t'(rd_item[ITEM_BITS-1 -: OP_BITS]);
  assign head_value    = rd_item[POSITION_BITS +: VALUE_BITS];
  assign head_position = rd_item[POSITION_BITS-1:0];

endmodule

>>> rtl/msnf_back.sv
// Back end: stack engine that carries out queued operations and emits results.
module msnf_back
  import msnf_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  op_t                             head_op,
  input  logic signed [VALUE_BITS-1:0]    head_value,
  input  logic        [POSITION_BITS-1:0] head_position,
  output logic                            head_pop,
  output logic                            res_wr,
  output logic        [POSITION_BITS-1:0] res_position,
  output logic signed [VALUE_BITS-1:0]    res_value,
  output res_flags_t                      res_flags,
  input  logic                            res_full
);

  localparam int ADDR_BITS  = $clog2(STACK_DEPTH);
  localparam int CNT_BITS   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_BITS = VALUE_BITS + POSITION_BITS;

  logic        [CNT_BITS-1:0]      count;
  logic        [CNT_BITS-1:0]      count_m2;
  logic                            reload;
  logic signed [VALUE_BITS-1:0]    top_value;
  logic        [POSITION_BITS-1:0] top_position;
  logic                            hold_valid;
  logic                            hold_valid_next;
  logic        [POSITION_BITS-1:0] hold_position;
  logic signed [VALUE_BITS-1:0]    hold_value;

  logic [ENTRY_BITS-1:0]           rd_entry;
  logic signed [VALUE_BITS-1:0]    cur_value;
  logic        [POSITION_BITS-1:0] cur_position;
  logic                            nonempty;
  logic                            stack_full;
  logic                            top_less;
  logic                            step;
  logic                            pop_en;
  logic                            push_en;
  logic                            clear_en;
  logic                            hold_load;

  // Entry count-1 lives in the top registers; after a pop the RAM word read
  // at count-2 is the new top, so take it straight from the read port.
  assign count_m2     = count - CNT_BITS'(2);
  assign cur_value    = reload ? $signed(rd_entry[ENTRY_BITS-1 -: VALUE_BITS]) : top_value;
  assign cur_position = reload ? rd_entry[POSITION_BITS-1:0] : top_position;
  assign nonempty     = (count != '0);
  assign stack_full   = (count == CNT_BITS'(STACK_DEPTH));
  assign top_less     = (cur_value < head_value);
  assign step         = head_valid && !res_full;

  msnf_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (count[ADDR_BITS-1:0]),
    .wr_data ({head_value, head_position}),
    .rd_addr (count_m2[ADDR_BITS-1:0]),
    .rd_data (rd_entry)
  );

  always_comb begin
    head_pop        = 1'b0;
    res_wr          = 1'b0;
    res_position    = head_position;
    res_value       = '0;
    res_flags       = '{found: 1'b0, status: 1'b0, last_of_run: 1'b1};
    pop_en          = 1'b0;
    push_en         = 1'b0;
    clear_en        = 1'b0;
    hold_load       = 1'b0;
    hold_valid_next = hold_valid;
    if (step) begin
      unique case (head_op)
        OP_FLUSH_REPORT: begin
          // Drain top first, one word per cycle while the result queue has room.
          if (nonempty) begin
            res_wr       = 1'b1;
            res_position = cur_position;
            res_flags    = '{found: 1'b0, status: 1'b0,
                             last_of_run: (count == CNT_BITS'(1))};
            pop_en       = 1'b1;
            head_pop     = (count == CNT_BITS'(1));
          end else begin
            head_pop = 1'b1;
          end
        end
        OP_FLUSH_CLEAR: begin
          clear_en = 1'b1;
          head_pop = 1'b1;
        end
        OP_PUSH_GREATER: begin
          // Hold each answer back in the hold registers so the last one can be marked.
          if (nonempty && top_less) begin
            pop_en          = 1'b1;
            hold_load       = 1'b1;
            hold_valid_next = 1'b1;
            if (hold_valid) begin
              res_wr       = 1'b1;
              res_position = hold_position;
              res_value    = hold_value;
              res_flags    = '{found: 1'b1, status: 1'b0, last_of_run: 1'b0};
            end
          end else begin
            head_pop        = 1'b1;
            hold_valid_next = 1'b0;
            if (hold_valid) begin
              // A pop happened, so there is room for the new entry.
              res_wr       = 1'b1;
              res_position = hold_position;
              res_value    = hold_value;
              res_flags    = '{found: 1'b1, status: 1'b0, last_of_run: 1'b1};
              push_en      = 1'b1;
            end else if (stack_full) begin
              res_wr    = 1'b1;
              res_flags = '{found: 1'b0, status: 1'b1, last_of_run: 1'b1};
            end else begin
              push_en = 1'b1;
            end
          end
        end
        default: begin
          // Smaller mode: drop entries not below the new value, then answer.
          if (nonempty && !top_less) begin
            pop_en = 1'b1;
          end else begin
            head_pop = 1'b1;
            res_wr   = 1'b1;
            if (stack_full) begin
              res_flags = '{found: 1'b1 & 1'b0, status: 1'b1, last_of_run: 1'b1};
            end else begin
              push_en = 1'b1;
              if (nonempty) begin
                res_value = cur_value;
                res_flags = '{found: 1'b1, status: 1'b0, last_of_run: 1'b1};
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      top_value    <= head_value;
      top_position <= head_position;
    end else begin
      top_value    <= cur_value;
      top_position <= cur_position;
    end
    if (hold_load) begin
      hold_position <= cur_position;
      hold_value    <= head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      reload     <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
      reload     <= pop_en;
      if (clear_en) begin
        count <= '0;
      end else if (pop_en) begin
        count <= count - CNT_BITS'(1);
      end else if (push_en) begin
        count <= count + CNT_BITS'(1);
      end
    end
  end

endmodule

>>> rtl/monotonic_stack_neighbor_finder.sv
// Top level of the monotonic stack neighbor finder (next greater / nearest smaller).
//
//  channel   handshake           words carried
//  -------   ---------------     ------------------------------------------------
//  input     push / full         command, elem_value, elem_position
//  result    pop / empty         answer_position, neighbor_value, found, status,
//                                last_of_run
//  config    cfg_valid/cfg_ready cfg_data (mode: 0 next greater, 1 nearest smaller)
//
//  A push removes the stacked entries it displaces one at a time, then stacks
//  the new entry, or answers with status set if the stack is full; a
//  greater-mode flush drains stacked entries one at a time, a smaller-mode
//  flush clears the stack at once. Each element enters and leaves the stack
//  once, through the single stack RAM port pair. Input and result words each
//  pass a two-word queue. Reset clears the stack count, both queues and the
//  mode; stack RAM contents are not cleared and need no clearing pass. A full
//  result queue stalls the engine; a full input queue raises full.
module monotonic_stack_neighbor_finder
  import msnf_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data,
  // input queue side
  input  logic                            push,
  output logic                            full,
  input  logic                            command,
  input  logic signed [VALUE_BITS-1:0]    elem_value,
  input  logic        [POSITION_BITS-1:0] elem_position,
  // result queue side
  output logic                            empty,
  input  logic                            pop,
  output logic        [POSITION_BITS-1:0] answer_position,
  output logic signed [VALUE_BITS-1:0]    neighbor_value,
  output logic                            found,
  output logic                            status,
  output logic                            last_of_run
);

  localparam int RES_BITS = POSITION_BITS + VALUE_BITS + FLAG_BITS;

  logic                            mode;
  logic                            head_valid;
  op_t                             head_op;
  logic signed [VALUE_BITS-1:0]    head_value;
  logic        [POSITION_BITS-1:0] head_position;
  logic                            head_pop;
  logic                            res_wr;
  logic        [POSITION_BITS-1:0] res_position;
  logic signed [VALUE_BITS-1:0]    res_value;
  res_flags_t                      res_flags;
  logic                            res_full;
  logic        [RES_BITS-1:0]      res_word;
  logic        [RES_BITS-1:0]      out_word;
  res_flags_t                      out_flags;

  // Mode must be written only while idle; the block itself does not enforce this, so always take the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_GREATER;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Front: classify and queue incoming words.
  msnf_front #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .push          (push),
    .full          (full),
    .command       (command),
    .elem_value    (elem_value),
    .elem_position (elem_position),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .head_value    (head_value),
    .head_position (head_position),
    .head_pop      (head_pop)
  );

  // Back: stack engine.
  msnf_back #(
    .STACK_DEPTH   (STACK_DEPTH),
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .head_value    (head_value),
    .head_position (head_position),
    .head_pop      (head_pop),
    .res_wr        (res_wr),
    .res_position  (res_position),
    .res_value     (res_value),
    .res_flags     (res_flags),
    .res_full      (res_full)
  );

  // Result queue: hold finished words until the consumer pops them.
  assign res_word = {res_position, res_value, res_flags};

  msnf_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

  assign out_flags       = res_flags_t'(out_word[FLAG_BITS-1:0]);
  assign answer_position = out_word[RES_BITS-1 -: POSITION_BITS];
  assign neighbor_value  = out_word[FLAG_BITS +: VALUE_BITS];
  assign found           = out_flags.found;
  assign status          = out_flags.status;
  assign last_of_run     = out_flags.last_of_run;

endmodule

>>> tb/neighbor_answer_checker.sv
// Scoreboard for the neighbor finder: tracks the stack, predicts answers and compares them.
module neighbor_answer_checker
  import msnf_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic                                cfg_data,
  input  logic                                push,
  input  logic                                full,
  input  logic                                command,
  input  logic signed [VALUE_BITS_DEF-1:0]    elem_value,
  input  logic        [POSITION_BITS_DEF-1:0] elem_position,
  input  logic                                empty,
  input  logic                                pop,
  input  logic        [POSITION_BITS_DEF-1:0] answer_position,
  input  logic signed [VALUE_BITS_DEF-1:0]    neighbor_value,
  input  logic                                found,
  input  logic                                status,
  input  logic                                last_of_run,
  output int                                  answers_pending,
  output int                                  answers_seen,
  output int                                  mismatches
);

  typedef struct {
    logic        [POSITION_BITS_DEF-1:0] pos;
    logic signed [VALUE_BITS_DEF-1:0]    value;
    res_flags_t                          flags;
  } answer_t;

  answer_t answers_q[$];

  logic signed [VALUE_BITS_DEF-1:0]    stack_value [STACK_DEPTH_DEF];
  logic        [POSITION_BITS_DEF-1:0] stack_pos   [STACK_DEPTH_DEF];
  int                                  stack_used;
  logic                                cur_mode;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic add_answer(input logic [POSITION_BITS_DEF-1:0] p,
                            input logic signed [VALUE_BITS_DEF-1:0] v,
                            input logic f, input logic s);
    answer_t a;
    a.pos               = p;
    a.value             = v;
    a.flags.found       = f;
    a.flags.status      = s;
    a.flags.last_of_run = 1'b0;
    answers_q.push_back(a);
  endtask

  task automatic predict_word(input logic cmd,
                              input logic signed [VALUE_BITS_DEF-1:0] v,
                              input logic [POSITION_BITS_DEF-1:0] p);
    int      prior_count;
    answer_t tail;
    prior_count = answers_q.size();
    if (cmd == CMD_FLUSH) begin
      // greater mode still owes an answer to every stacked entry, top first
      if (cur_mode == MODE_GREATER) begin
        while (stack_used > 0) begin
          stack_used--;
          add_answer(stack_pos[stack_used], '0, 1'b0, 1'b0);
        end
      end
      stack_used = 0;
    end else begin
      if (cur_mode == MODE_GREATER) begin
        while (stack_used > 0 && stack_value[stack_used-1] < v) begin
          stack_used--;
          add_answer(stack_pos[stack_used], v, 1'b1, 1'b0);
        end
      end else begin
        while (stack_used > 0 && stack_value[stack_used-1] >= v) begin
          stack_used--;
        end
      end
      if (stack_used >= STACK_DEPTH_DEF) begin
        add_answer(p, '0, 1'b0, 1'b1);
      end else begin
        if (cur_mode == MODE_SMALLER) begin
          if (stack_used > 0) begin
            add_answer(p, stack_value[stack_used-1], 1'b1, 1'b0);
          end else begin
            add_answer(p, '0, 1'b0, 1'b0);
          end
        end
        stack_value[stack_used] = v;
        stack_pos[stack_used]   = p;
        stack_used++;
      end
    end
    // mark the final answer this word caused
    if (answers_q.size() > prior_count) begin
      tail = answers_q.pop_back();
      tail.flags.last_of_run = 1'b1;
      answers_q.push_back(tail);
    end
  endtask

  task automatic check_answer();
    answer_t want;
    if (answers_q.size() == 0) begin
      report_mismatch($sformatf("answer for position %0d with nothing expected",
                                answer_position));
    end else begin
      want = answers_q.pop_front();
      answers_seen++;
      if (answer_position !== want.pos) begin
        report_mismatch($sformatf("answer_position %0d, expected %0d",
                                  answer_position, want.pos));
      end
      if (neighbor_value !== want.value) begin
        report_mismatch($sformatf("neighbor_value %0d at position %0d, expected %0d",
                                  neighbor_value, want.pos, want.value));
      end
      if (found !== want.flags.found) begin
        report_mismatch($sformatf("found %b at position %0d, expected %b",
                                  found, want.pos, want.flags.found));
      end
      if (status !== want.flags.status) begin
        report_mismatch($sformatf("status %b at position %0d, expected %b",
                                  status, want.pos, want.flags.status));
      end
      if (last_of_run !== want.flags.last_of_run) begin
        report_mismatch($sformatf("last_of_run %b at position %0d, expected %b",
                                  last_of_run, want.pos, want.flags.last_of_run));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      answers_q.delete();
      stack_used   = 0;
      cur_mode     = MODE_GREATER;
      answers_seen = 0;
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cur_mode = cfg_data;
      end
      if (push && !full) begin
        predict_word(command, elem_value, elem_position);
      end
      if (pop && !empty) begin
        check_answer();
      end
    end
    answers_pending <= answers_q.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the neighbor finder testbench: clock, reset, stimulus and verdict.
module testbench
  import msnf_pkg::*;
;

  // Cycles to let the engine finish words that cause no answer (pushes that
  // pop nothing, smaller-mode flushes) before touching the mode register.
  localparam int SETTLE_CYCLES = 100;
  localparam int FILL_WORDS    = STACK_DEPTH_DEF + 2;

  typedef enum int {SPREAD_NARROW, SPREAD_FULL, SPREAD_EDGES} spread_t;

  logic                                clk           = 1'b0;
  logic                                rst           = 1'b1;
  logic                                cfg_valid     = 1'b0;
  logic                                cfg_data      = MODE_GREATER;
  logic                                push          = 1'b0;
  logic                                command       = CMD_PUSH;
  logic signed [VALUE_BITS_DEF-1:0]    elem_value    = '0;
  logic        [POSITION_BITS_DEF-1:0] elem_position = '0;
  logic                                pop           = 1'b0;

  logic                                cfg_ready;
  logic                                full;
  logic                                empty;
  logic        [POSITION_BITS_DEF-1:0] answer_position;
  logic signed [VALUE_BITS_DEF-1:0]    neighbor_value;
  logic                                found;
  logic                                status;
  logic                                last_of_run;

  int answers_pending;
  int answers_seen;
  int mismatches;

  // Percent of cycles in which the sender holds off or the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int words_sent = 0;

  always #5 clk = ~clk;

  monotonic_stack_neighbor_finder uut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .command         (command),
    .elem_value      (elem_value),
    .elem_position   (elem_position),
    .empty           (empty),
    .pop             (pop),
    .answer_position (answer_position),
    .neighbor_value  (neighbor_value),
    .found           (found),
    .status          (status),
    .last_of_run     (last_of_run)
  );

  neighbor_answer_checker answer_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .command         (command),
    .elem_value      (elem_value),
    .elem_position   (elem_position),
    .empty           (empty),
    .pop             (pop),
    .answer_position (answer_position),
    .neighbor_value  (neighbor_value),
    .found           (found),
    .status          (status),
    .last_of_run     (last_of_run),
    .answers_pending (answers_pending),
    .answers_seen    (answers_seen),
    .mismatches      (mismatches)
  );

  // Receiver: redraw pop every cycle; at zero stall it stays high.
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hard stop in case the block hangs or holds back answers.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [POSITION_BITS_DEF-1:0] rand_position();
    return POSITION_BITS_DEF'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Present one word and hold it until the block takes it. Push is only
  // dropped ahead of a gap, so back-to-back words keep push high throughout.
  task automatic send_word(input logic cmd,
                           input logic signed [VALUE_BITS_DEF-1:0] v,
                           input logic [POSITION_BITS_DEF-1:0] p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push          <= 1'b1;
    command       <= cmd;
    elem_value    <= v;
    elem_position <= p;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // Hold the sender off until every predicted answer has been popped.
  task automatic drain_answers();
    push <= 1'b0;
    do @(posedge clk); while (answers_pending != 0);
  endtask

  // Change mode only with the block quiet: drain, let silent words finish,
  // then write through the config channel.
  task automatic write_mode(input logic m);
    drain_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VALUE_BITS_DEF-1:0] pick_value(input spread_t spread);
    logic signed [VALUE_BITS_DEF-1:0] v;
    case (spread)
      // tight range around zero, so ties are common
      SPREAD_NARROW: v = VALUE_BITS_DEF'(int'($urandom_range(0, 15)) - 8);
      SPREAD_FULL:   v = VALUE_BITS_DEF'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}};
          1:       v = {1'b0, {(VALUE_BITS_DEF-1){1'b1}}};
          2:       v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Push a run in stacking order: non-increasing (with ties) for greater mode,
  // strictly increasing for smaller mode, so the run pops none of its own entries.
  task automatic send_trend(input logic m, input int len);
    logic signed [VALUE_BITS_DEF-1:0] v;
    int                               i;
    if (m == MODE_GREATER) begin
      v = {1'b0, {(VALUE_BITS_DEF-1){1'b1}}} - VALUE_BITS_DEF'($urandom_range(0, 1000));
    end else begin
      v = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}} + VALUE_BITS_DEF'($urandom_range(0, 1000));
    end
    for (i = 0; i < len; i++) begin
      send_word(CMD_PUSH, v, POSITION_BITS_DEF'(i));
      if (m == MODE_GREATER) begin
        v = v - VALUE_BITS_DEF'($urandom_range(0, 3));
      end else begin
        v = v + VALUE_BITS_DEF'($urandom_range(1, 1000));
      end
    end
  endtask

  // One array: elements in scan order, or reversed positions for the twin
  // scan; optionally closed by a flush. Flush values are random, as they
  // must be ignored.
  task automatic send_array(input int len, input spread_t spread,
                            input bit reversed, input bit closed);
    int i;
    for (i = 0; i < len; i++) begin
      send_word(CMD_PUSH, pick_value(spread),
                POSITION_BITS_DEF'(reversed ? len - 1 - i : i));
    end
    if (closed) begin
      send_word(CMD_FLUSH, pick_value(SPREAD_FULL), rand_position());
    end
  endtask

  // A random phase: set the mode and idling, optionally overfill the stack
  // first, then mostly well-formed arrays with some noise and unclosed runs.
  // Halfway through, pause the sender until all answers are out.
  task automatic run_phase(input logic m, input int send_pct, input int recv_pct,
                           input int n_words, input bit overfill);
    int  start;
    bit  paused;
    int  pick;
    write_mode(m);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start  = words_sent;
    paused = 1'b0;
    if (overfill) begin
      // empty the stack, then push past its depth so the last pushes drop
      send_word(CMD_FLUSH, pick_value(SPREAD_FULL), rand_position());
      send_trend(m, FILL_WORDS);
      send_word(CMD_FLUSH, pick_value(SPREAD_FULL), rand_position());
    end
    while (words_sent - start < n_words) begin
      if (!paused && words_sent - start >= n_words / 2) begin
        drain_answers();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        send_array($urandom_range(1, 12), spread_t'($urandom_range(0, 2)),
                   rand_bit(), 1'b1);
      end else if (pick == 6) begin
        send_word(rand_bit(), pick_value(SPREAD_FULL), rand_position());
      end else if (pick == 7) begin
        // unclosed array: leaves entries for the next array or the next mode
        send_array($urandom_range(1, 8), spread_t'($urandom_range(0, 2)), 1'b0, 1'b0);
      end else if (pick == 8) begin
        send_trend(m, $urandom_range(4, 20));
      end else begin
        send_word(CMD_FLUSH, pick_value(SPREAD_FULL), rand_position());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, greater mode: empty flush, ties, extremes, pops of several
    // entries by one push, flush answering leftovers as not found.
    write_mode(MODE_GREATER);
    send_word(CMD_FLUSH, '0, 16'd0);
    send_word(CMD_PUSH, '0, 16'd0);
    send_word(CMD_PUSH, {1'b1, {(VALUE_BITS_DEF-1){1'b0}}}, 16'hffff);
    send_word(CMD_PUSH, {1'b0, {(VALUE_BITS_DEF-1){1'b1}}}, 16'd1);
    send_word(CMD_PUSH, {1'b0, {(VALUE_BITS_DEF-1){1'b1}}}, 16'd2);
    send_word(CMD_PUSH, '1, 16'd3);
    send_word(CMD_FLUSH, '1, 16'hffff);
    send_word(CMD_FLUSH, '0, 16'd0);

    // Directed, smaller mode: equal values pop, answers on push, flush is silent.
    write_mode(MODE_SMALLER);
    send_word(CMD_PUSH, {1'b1, {(VALUE_BITS_DEF-1){1'b0}}}, 16'd0);
    send_word(CMD_PUSH, {1'b1, {(VALUE_BITS_DEF-1){1'b0}}}, 16'd1);
    send_word(CMD_PUSH, {1'b0, {(VALUE_BITS_DEF-1){1'b1}}}, 16'hffff);
    send_word(CMD_PUSH, '0, 16'd2);
    send_word(CMD_PUSH, '1, 16'd3);
    send_word(CMD_FLUSH, '0, 16'd0);
    send_word(CMD_PUSH, 32'sd5, 16'd0);

    // Switch mode with one entry stacked: it must survive and pop in greater mode.
    write_mode(MODE_GREATER);
    send_word(CMD_PUSH, 32'sd6, 16'd1);
    send_word(CMD_FLUSH, '0, 16'd2);

    // Random phases under several idling patterns, alternating mode.
    run_phase(MODE_GREATER, 0, 0, 76, 1'b1);
    run_phase(MODE_SMALLER, 80, 0, 76, 1'b1);
    run_phase(MODE_GREATER, 0, 80, 36, 1'b0);
    run_phase(MODE_SMALLER, 12, 12, 36, 1'b0);
    run_phase(MODE_GREATER, 0, 0, 10, 1'b0);

    // Wait out the last answers, then give stray words time to show up.
    drain_answers();
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d input words in both modes, with overfilled stacks,",
             words_sent);
    $display("flushes and idling on both sides; %0d answers checked", answers_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/msnf_pkg.sv
rtl/msnf_ram.sv
rtl/msnf_fifo.sv
rtl/msnf_front.sv
rtl/msnf_back.sv
rtl/monotonic_stack_neighbor_finder.sv
tb/neighbor_answer_checker.sv
tb/testbench.sv
